>>> design/rdcm_pkg.sv
// Shared types and constants for the radial distortion coordinate map.
// No dependencies; every other design file imports this package.
package rdcm_pkg;

  localparam int MAX_DIM        = 16384;
  localparam int COEF_FRAC_BITS = 30;

  localparam int IDX_W  = 14;  // column and row index
  localparam int DIM_W  = 15;  // width and height registers
  localparam int P_W    = 17;  // centred offset, signed
  localparam int SQ_W   = 30;  // one squared offset
  localparam int S_W    = 31;  // sum of squares
  localparam int MSQ_W  = 29;  // min dimension squared
  localparam int QUO_W  = 48;  // radius squared, Q.32
  localparam int R_W    = 24;  // radius, Q.16
  localparam int R_FRAC = 16;
  localparam int T_W    = 39;  // Horner accumulator, signed
  localparam int OFF_W  = 22;
  localparam int COEF_W = 32;
  localparam int OUT_W  = 32;

  localparam int HP_W   = T_W + R_W + 1;
  localparam int MP_W   = P_W + T_W;
  localparam int DS_W   = DIM_W + COEF_FRAC_BITS + 1;
  localparam int NUM_W  = ((MP_W > DS_W) ? MP_W : DS_W) + 1;
  localparam int SH     = COEF_FRAC_BITS - 7;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_COEF_A   = 3'd0,
    REG_COEF_B   = 3'd1,
    REG_COEF_C   = 3'd2,
    REG_COEF_D   = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5,
    REG_OFFSET_X = 3'd6,
    REG_OFFSET_Y = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] src_x;
    logic signed [OUT_W-1:0] src_y;
  } out_t;

  // Configuration as seen by the datapath, with the sizes already clamped.
  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_d;
    logic [DIM_W-1:0]         dim_w;
    logic [DIM_W-1:0]         dim_h;
    logic signed [OFF_W-1:0]  offset_x;
    logic signed [OFF_W-1:0]  offset_y;
  } cfg_t;

endpackage

>>> design/radial_distortion_coordinate_map.sv
// Top level of the radial distortion coordinate map: register file, centring
// stage, output register. Depends on rdcm_pkg, rdcm_radius and rdcm_poly.
//
// Usage: each input beat carries a destination column and row; each output
// beat carries the source x and y in signed 1/256-pixel fixed point, one
// output beat for every input beat, in order.
// The radius is the long part: a restoring divider of 48 stages followed by
// a square root of 24 stages, one bit (or bit pair) per stage.
// Throughput is one beat per cycle while the receiver takes every beat.
// The whole pipeline advances together: when an output beat is held by
// out_stall_i, every stage holds and in_stall_o is raised, so nothing is
// lost or repeated.
// Reset clears all valid bits and loads the coefficients with a = 1.0,
// b = c = d = 0, a 1024 by 1024 image and zero offsets.
// The user must write registers over the APB port only while no beat is in
// flight; the clamped sizes, then min(W,H)^2, are registered from a write.
module radial_distortion_coordinate_map (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rdcm_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rdcm_pkg::out_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rdcm_pkg::ADDR_W-1:0]   paddr,
  input  logic [rdcm_pkg::DATA_W-1:0]   pwdata,
  output logic [rdcm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import rdcm_pkg::*;

  logic signed [COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
  logic [DIM_W-1:0]         width_q, height_q;
  logic signed [OFF_W-1:0]  off_x_q, off_y_q;
  logic [DIM_W-1:0]         dim_w_q, dim_h_q;
  logic [MSQ_W-1:0]         msq_q;
  reg_idx_e                 widx;
  logic                     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign widx   = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= COEF_W'(64'sd1 <<< COEF_FRAC_BITS);
      coef_b_q <= '0;
      coef_c_q <= '0;
      coef_d_q <= '0;
      width_q  <= DIM_W'(1024);
      height_q <= DIM_W'(1024);
      off_x_q  <= '0;
      off_y_q  <= '0;
    end else if (wr_en) begin
      case (widx)
        REG_COEF_A:   coef_a_q <= pwdata;
        REG_COEF_B:   coef_b_q <= pwdata;
        REG_COEF_C:   coef_c_q <= pwdata;
        REG_COEF_D:   coef_d_q <= pwdata;
        REG_WIDTH:    width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT:   height_q <= pwdata[DIM_W-1:0];
        REG_OFFSET_X: off_x_q  <= pwdata[OFF_W-1:0];
        REG_OFFSET_Y: off_y_q  <= pwdata[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_COEF_A:   prdata = coef_a_q;
      REG_COEF_B:   prdata = coef_b_q;
      REG_COEF_C:   prdata = coef_c_q;
      REG_COEF_D:   prdata = coef_d_q;
      REG_WIDTH:    prdata = DATA_W'(width_q);
      REG_HEIGHT:   prdata = DATA_W'(height_q);
      REG_OFFSET_X: prdata = DATA_W'(off_x_q);
      REG_OFFSET_Y: prdata = DATA_W'(off_y_q);
      default:      prdata = '0;
    endcase
  end

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      clamp_dim = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      clamp_dim = DIM_W'(MAX_DIM);
    end else begin
      clamp_dim = v;
    end
  endfunction

  logic [DIM_W-1:0]   dim_m;
  logic [2*DIM_W-1:0] msq_full;

  assign dim_m    = (dim_w_q < dim_h_q) ? dim_w_q : dim_h_q;
  assign msq_full = dim_m * dim_m;

  // Derived values track the registers; the user must change them only while idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_w_q <= DIM_W'(1024);
      dim_h_q <= DIM_W'(1024);
      msq_q   <= MSQ_W'(1024 * 1024);
    end else begin
      dim_w_q <= clamp_dim(width_q);
      dim_h_q <= clamp_dim(height_q);
      msq_q   <= msq_full[MSQ_W-1:0];
    end
  end

  cfg_t cfg;
  assign cfg.coef_a   = coef_a_q;
  assign cfg.coef_b   = coef_b_q;
  assign cfg.coef_c   = coef_c_q;
  assign cfg.coef_d   = coef_d_q;
  assign cfg.dim_w    = dim_w_q;
  assign cfg.dim_h    = dim_h_q;
  assign cfg.offset_x = off_x_q;
  assign cfg.offset_y = off_y_q;

  // Pipeline advances unless the output register holds a beat that is refused.
  logic adv;
  logic out_valid_q;
  out_t out_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  logic                  f_v_q;
  logic signed [P_W-1:0] f_px_q, f_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (adv) begin
      f_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_px_q <= $signed({2'b00, in_data_i.col, 1'b1}) - $signed({2'b00, dim_w_q});
      f_py_q <= $signed({2'b00, in_data_i.row, 1'b1}) - $signed({2'b00, dim_h_q});
    end
  end

  logic                  r_v;
  logic signed [P_W-1:0] r_px, r_py;
  logic [R_W-1:0]        r_val;

  rdcm_radius u_radius (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (f_v_q),
    .px_i    (f_px_q),
    .py_i    (f_py_q),
    .msq_i   (msq_q),
    .valid_o (r_v),
    .px_o    (r_px),
    .py_o    (r_py),
    .r_o     (r_val)
  );

  logic p_v;
  out_t p_data;

  rdcm_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cfg_i   (cfg),
    .valid_i (r_v),
    .px_i    (r_px),
    .py_i    (r_py),
    .r_i     (r_val),
    .valid_o (p_v),
    .data_o  (p_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= p_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= p_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A refused output beat must freeze the whole pipeline, input side included.
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a refused output beat");

  a_hold_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("held output beat changed");

  a_derived_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dim_w_q != '0) && (dim_h_q != '0) && (dim_w_q <= DIM_W'(MAX_DIM)))
    else $error("clamped image size out of range");

endmodule

>>> design/rdcm_radius.sv
// Radius pipeline: squares, restoring divider by min(W,H)^2 and square root.
// Depends on rdcm_pkg.
module rdcm_radius (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic signed [rdcm_pkg::P_W-1:0] px_i,
  input  logic signed [rdcm_pkg::P_W-1:0] py_i,
  input  logic [rdcm_pkg::MSQ_W-1:0]    msq_i,
  output logic                          valid_o,
  output logic signed [rdcm_pkg::P_W-1:0] px_o,
  output logic signed [rdcm_pkg::P_W-1:0] py_o,
  output logic [rdcm_pkg::R_W-1:0]      r_o
);
  import rdcm_pkg::*;

  localparam int LO_W  = S_W - R_FRAC;
  localparam int RM_W  = R_W + 2;

  logic signed [2*P_W-1:0] sqx_full, sqy_full;
  logic              b_v_q;
  logic [SQ_W-1:0]   b_sqx_q, b_sqy_q;
  logic signed [P_W-1:0] b_px_q, b_py_q;

  assign sqx_full = px_i * px_i;
  assign sqy_full = py_i * py_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (adv_i) begin
      b_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_sqx_q <= sqx_full[SQ_W-1:0];
      b_sqy_q <= sqy_full[SQ_W-1:0];
      b_px_q  <= px_i;
      b_py_q  <= py_i;
    end
  end

  // Divider: element 0 holds the sum of squares, one quotient bit per stage.
  logic              d_v   [0:QUO_W];
  logic [MSQ_W-1:0]  d_rem [0:QUO_W];
  logic [R_FRAC-1:0] d_lo  [0:QUO_W];
  logic [QUO_W-1:0]  d_quo [0:QUO_W];
  logic              d_ovf [0:QUO_W];
  logic signed [P_W-1:0] d_px [0:QUO_W];
  logic signed [P_W-1:0] d_py [0:QUO_W];

  logic [S_W-1:0] s_sum;
  logic           s_ovf;

  assign s_sum = {1'b0, b_sqx_q} + {1'b0, b_sqy_q};
  // The quotient only matters below 2^48; anything above saturates the radius.
  assign s_ovf = {{(MSQ_W + R_FRAC - S_W){1'b0}}, s_sum} >= {msq_i, {R_FRAC{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v[0] <= 1'b0;
    end else if (adv_i) begin
      d_v[0] <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_rem[0] <= {{(MSQ_W-LO_W){1'b0}}, s_sum[S_W-1:R_FRAC]};
      d_lo[0]  <= s_sum[R_FRAC-1:0];
      d_quo[0] <= '0;
      d_ovf[0] <= s_ovf;
      d_px[0]  <= b_px_q;
      d_py[0]  <= b_py_q;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_div
    logic [MSQ_W:0] trial;
    logic           take;

    assign trial = {d_rem[k-1], d_lo[k-1][R_FRAC-1]};
    assign take  = trial >= {1'b0, msq_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v[k] <= 1'b0;
      end else if (adv_i) begin
        d_v[k] <= d_v[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        d_rem[k] <= take ? MSQ_W'(trial - {1'b0, msq_i}) : trial[MSQ_W-1:0];
        d_lo[k]  <= {d_lo[k-1][R_FRAC-2:0], 1'b0};
        d_quo[k] <= {d_quo[k-1][QUO_W-2:0], take};
        d_ovf[k] <= d_ovf[k-1];
        d_px[k]  <= d_px[k-1];
        d_py[k]  <= d_py[k-1];
      end
    end
  end

  // Square root, two radicand bits per stage.
  logic              q_v    [0:R_W];
  logic [QUO_W-1:0]  q_rad  [0:R_W];
  logic [RM_W-1:0]   q_rem  [0:R_W];
  logic [R_W-1:0]    q_root [0:R_W];
  logic signed [P_W-1:0] q_px [0:R_W];
  logic signed [P_W-1:0] q_py [0:R_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_v[0] <= 1'b0;
    end else if (adv_i) begin
      q_v[0] <= d_v[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // An all-ones radicand roots to the saturated radius.
      q_rad[0]  <= d_ovf[QUO_W] ? {QUO_W{1'b1}} : d_quo[QUO_W];
      q_rem[0]  <= '0;
      q_root[0] <= '0;
      q_px[0]   <= d_px[QUO_W];
      q_py[0]   <= d_py[QUO_W];
    end
  end

  for (genvar j = 1; j <= R_W; j++) begin : g_sqrt
    logic [RM_W+1:0] cur;
    logic [RM_W+1:0] tst;
    logic            take;

    assign cur  = {q_rem[j-1], q_rad[j-1][QUO_W-1:QUO_W-2]};
    assign tst  = {2'b00, q_root[j-1], 2'b01};
    assign take = cur >= tst;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        q_v[j] <= 1'b0;
      end else if (adv_i) begin
        q_v[j] <= q_v[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        q_rad[j]  <= {q_rad[j-1][QUO_W-3:0], 2'b00};
        q_rem[j]  <= take ? RM_W'(cur - tst) : cur[RM_W-1:0];
        q_root[j] <= {q_root[j-1][R_W-2:0], take};
        q_px[j]   <= q_px[j-1];
        q_py[j]   <= q_py[j-1];
      end
    end
  end

  assign valid_o = q_v[R_W];
  assign px_o    = q_px[R_W];
  assign py_o    = q_py[R_W];
  assign r_o     = q_root[R_W];

endmodule

>>> design/rdcm_poly.sv
// Scale polynomial by Horner's rule and the per-axis source mapping.
// Depends on rdcm_pkg.
module rdcm_poly (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  rdcm_pkg::cfg_t                  cfg_i,
  input  logic                            valid_i,
  input  logic signed [rdcm_pkg::P_W-1:0] px_i,
  input  logic signed [rdcm_pkg::P_W-1:0] py_i,
  input  logic [rdcm_pkg::R_W-1:0]        r_i,
  output logic                            valid_o,
  output rdcm_pkg::out_t                  data_o
);
  import rdcm_pkg::*;

  localparam int NS    = 3;
  localparam int SUM_W = HP_W - R_FRAC + 1;
  localparam int SH_W  = NUM_W - SH;
  localparam int V_W   = ((SH_W > OFF_W) ? SH_W : OFF_W) + 1;

  localparam logic signed [SUM_W-1:0] T_MAX = SUM_W'((64'sd1 <<< (T_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] T_MIN = -T_MAX;
  localparam logic signed [V_W-1:0]   O_MAX = V_W'(64'sd2147483647);
  localparam logic signed [V_W-1:0]   O_MIN = V_W'(-64'sd2147483648);

  logic signed [COEF_W-1:0] coef_sel [0:NS-1];
  assign coef_sel[0] = cfg_i.coef_c;
  assign coef_sel[1] = cfg_i.coef_b;
  assign coef_sel[2] = cfg_i.coef_a;

  // Stage pairs: product register, then add and saturate.
  logic                  m_v  [0:NS-1];
  logic signed [HP_W-1:0] m_p [0:NS-1];
  logic [R_W-1:0]        m_r  [0:NS-1];
  logic signed [P_W-1:0] m_px [0:NS-1];
  logic signed [P_W-1:0] m_py [0:NS-1];
  logic                  a_v  [0:NS-1];
  logic signed [T_W-1:0] a_t  [0:NS-1];
  logic [R_W-1:0]        a_r  [0:NS-1];
  logic signed [P_W-1:0] a_px [0:NS-1];
  logic signed [P_W-1:0] a_py [0:NS-1];

  for (genvar i = 0; i < NS; i++) begin : g_horner
    logic signed [T_W-1:0]   t_src;
    logic [R_W-1:0]          r_src;
    logic signed [P_W-1:0]   px_src, py_src;
    logic                    v_src;
    logic signed [R_W:0]     r_s;
    logic signed [SUM_W-1:0] sum;

    if (i == 0) begin : g_first
      assign t_src  = T_W'(cfg_i.coef_d);
      assign r_src  = r_i;
      assign px_src = px_i;
      assign py_src = py_i;
      assign v_src  = valid_i;
    end else begin : g_next
      assign t_src  = a_t[i-1];
      assign r_src  = a_r[i-1];
      assign px_src = a_px[i-1];
      assign py_src = a_py[i-1];
      assign v_src  = a_v[i-1];
    end

    assign r_s = {1'b0, r_src};
    assign sum = SUM_W'(coef_sel[i]) + SUM_W'(m_p[i] >>> R_FRAC);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        m_v[i] <= 1'b0;
        a_v[i] <= 1'b0;
      end else if (adv_i) begin
        m_v[i] <= v_src;
        a_v[i] <= m_v[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        m_p[i]  <= t_src * r_s;
        m_r[i]  <= r_src;
        m_px[i] <= px_src;
        m_py[i] <= py_src;
        if (sum > T_MAX) begin
          a_t[i] <= T_MAX[T_W-1:0];
        end else if (sum < T_MIN) begin
          a_t[i] <= T_MIN[T_W-1:0];
        end else begin
          a_t[i] <= sum[T_W-1:0];
        end
        a_r[i]  <= m_r[i];
        a_px[i] <= m_px[i];
        a_py[i] <= m_py[i];
      end
    end
  end

  // Axis mapping: p*scale, then add the size term, shift down, offset and saturate.
  logic                   x_v_q;
  logic signed [MP_W-1:0] x_px_q, x_py_q;
  logic                   o_v_q;
  out_t                   o_q;

  logic signed [NUM_W-1:0] num_x, num_y;
  logic signed [SH_W-1:0]  sh_x, sh_y;
  logic signed [V_W-1:0]   v_x, v_y;

  assign num_x = NUM_W'(x_px_q) + (NUM_W'($signed({1'b0, cfg_i.dim_w})) <<< COEF_FRAC_BITS);
  assign num_y = NUM_W'(x_py_q) + (NUM_W'($signed({1'b0, cfg_i.dim_h})) <<< COEF_FRAC_BITS);
  assign sh_x  = SH_W'(num_x >>> SH);
  assign sh_y  = SH_W'(num_y >>> SH);
  assign v_x   = V_W'(sh_x) + V_W'(cfg_i.offset_x);
  assign v_y   = V_W'(sh_y) + V_W'(cfg_i.offset_y);

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [V_W-1:0] v);
    if (v > O_MAX) begin
      sat32 = O_MAX[OUT_W-1:0];
    end else if (v < O_MIN) begin
      sat32 = O_MIN[OUT_W-1:0];
    end else begin
      sat32 = v[OUT_W-1:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (adv_i) begin
      x_v_q <= a_v[NS-1];
      o_v_q <= x_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_px_q    <= a_px[NS-1] * a_t[NS-1];
      x_py_q    <= a_py[NS-1] * a_t[NS-1];
      o_q.src_x <= sat32(v_x);
      o_q.src_y <= sat32(v_y);
    end
  end

  assign valid_o = o_v_q;
  assign data_o  = o_q;

endmodule
